// ===== design/lpmm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmm_pkg: shared constants, types and helpers for the linear partition block
// Sizes of the weight store and the sums, controller command and status
// bundles, register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmm_pkg;

  // store depth and stored weight width
  localparam int MAX_ITEMS   = 1024;
  localparam int WEIGHT_BITS = 16;

  // fixed field widths of the channels and the register
  localparam int IN_WEIGHT_W = 16;
  localparam int RESULT_W    = 26;
  localparam int PC_W        = 11;

  // derived widths
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUM_W  = WEIGHT_BITS + CNT_W;
  localparam int GRP_W  = PC_W + 1;
  localparam int WIDE_W = SUM_W + RESULT_W;

  // largest value the result field can show
  localparam logic [RESULT_W-1:0] SUM_LIMIT = {RESULT_W{1'b1}};

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_PARTITION_COUNT = '0;
  localparam logic [PC_W-1:0]      PC_RESET            = PC_W'(1);

  // controller to datapath commands
  typedef struct packed {
    logic load;      // store an accepted item
    logic init;      // set up search bounds
    logic mid_calc;  // take a new candidate cap and rewind the pass
    logic pass_step; // advance the greedy pass
    logic decide;    // narrow the bounds after a pass
    logic emit;      // register the result and clear the run
  } lpmm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic range_ok;  // low bound at or below high bound
    logic pass_done; // all stored items went through the pass
    logic fits;      // candidate cap needs no more groups than allowed
    logic mid_zero;  // candidate cap is zero
    logic out_free;  // output register can take a result
  } lpmm_sts_t;

  // clamp a full precision sum to the result field
  function automatic logic [RESULT_W-1:0] sat_result(input logic [SUM_W-1:0] v);
    logic [WIDE_W-1:0] ext;
    ext = WIDE_W'(v);
    if (ext > WIDE_W'(SUM_LIMIT)) begin
      return SUM_LIMIT;
    end else begin
      return RESULT_W'(ext);
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/lpmm_if.sv =====
// ----------------------------------------------------------------------------
// lpmm_if: request channels of the linear partition block
// Item channel carries weights in order, result channel the smallest cap.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpmm_item_if import lpmm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IN_WEIGHT_W-1:0] weight;
  logic                   last_item;

  modport source (output valid, output weight, output last_item, input ready);
  modport sink   (input valid, input weight, input last_item, output ready);
endinterface

interface lpmm_result_if import lpmm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] min_max_sum;
  logic                overflow;

  modport source (output valid, output min_max_sum, output overflow, input ready);
  modport sink   (input valid, input min_max_sum, input overflow, output ready);
endinterface

`default_nettype wire

// ===== design/lpmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpmm_ctrl: sequencer of the linear partition block
// Loads items, then runs the binary search on the cap: one greedy pass over
// the store for each candidate, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmm_ctrl import lpmm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_last_i,
  output logic           in_ready_o,
  input  wire lpmm_sts_t sts_i,
  output lpmm_cmd_t      cmd_o
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_MID    = 3'd2;
  localparam logic [2:0] S_PASS   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load = accept;
        if (accept && in_last_i) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_MID;
      end
      S_MID: begin
        if (sts_i.range_ok) begin
          cmd_o.mid_calc = 1'b1;
          state_d        = S_PASS;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_PASS: begin
        cmd_o.pass_step = 1'b1;
        if (sts_i.pass_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.fits && sts_i.mid_zero) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_MID;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/lpmm_dp.sv =====
// ----------------------------------------------------------------------------
// lpmm_dp: datapath of the linear partition block
// Weight store, running maximum and total, search bounds, greedy pass
// accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmm_dp import lpmm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lpmm_cmd_t              cmd_i,
  output lpmm_sts_t                   sts_o,
  input  wire logic [IN_WEIGHT_W-1:0] weight_i,
  input  wire logic [PC_W-1:0]        partition_count_i,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [RESULT_W-1:0]         min_max_sum_o,
  output logic                        overflow_o
);

  // weight store
  logic [WEIGHT_BITS-1:0] store_mem [MAX_ITEMS];

  // run state
  logic [CNT_W-1:0]       count_q;
  logic [WEIGHT_BITS-1:0] max_q;
  logic [SUM_W-1:0]       total_q;
  logic                   ovf_q;

  // search state
  logic [SUM_W-1:0] low_q, high_q, best_q, mid_q;

  // pass state
  logic [CNT_W-1:0]       rd_idx_q;
  logic                   rd_valid_q;
  logic [WEIGHT_BITS-1:0] rd_data_q;
  logic [SUM_W-1:0]       sum_q;
  logic [GRP_W-1:0]       groups_q;
  logic                   fail_q;

  // output register
  logic                out_valid_q;
  logic [RESULT_W-1:0] res_q;
  logic                res_ovf_q;

  logic [WEIGHT_BITS-1:0] w_in;
  logic                   wr_en, rd_en, store_full;
  logic [SUM_W-1:0]       add_sum, w_ext;
  logic [GRP_W-1:0]       groups_inc;

  assign w_in       = WEIGHT_BITS'(weight_i);
  assign store_full = (count_q == CNT_W'(MAX_ITEMS));
  assign wr_en      = cmd_i.load && !store_full;
  assign rd_en      = cmd_i.pass_step && (rd_idx_q != count_q);
  assign w_ext      = SUM_W'(rd_data_q);
  assign add_sum    = sum_q + w_ext;
  assign groups_inc = groups_q + GRP_W'(1);

  // store write while loading, read during the pass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[count_q[ADDR_W-1:0]] <= w_in;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_idx_q[ADDR_W-1:0]];
    end
  end

  // running count, maximum, total and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q   <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      count_q <= '0;
      max_q   <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (store_full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + CNT_W'(1);
        total_q <= total_q + SUM_W'(w_in);
        if (w_in > max_q) begin
          max_q <= w_in;
        end
      end
    end
  end

  // search bounds and candidate cap
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      low_q  <= SUM_W'(max_q);
      high_q <= total_q;
      best_q <= total_q;
    end else if (cmd_i.mid_calc) begin
      mid_q <= low_q + ((high_q - low_q) >> 1);
    end else if (cmd_i.decide) begin
      if (!fail_q) begin
        best_q <= mid_q;
        if (mid_q != '0) begin
          high_q <= mid_q - SUM_W'(1);
        end
      end else begin
        low_q <= mid_q + SUM_W'(1);
      end
    end
  end

  // read issue for the greedy pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      rd_valid_q <= 1'b0;
    end else if (cmd_i.mid_calc) begin
      rd_idx_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en;
      if (rd_en) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
    end
  end

  // greedy grouping: open a new group when the next weight would pass the cap
  always_ff @(posedge clk_i) begin
    if (cmd_i.mid_calc) begin
      sum_q    <= '0;
      groups_q <= GRP_W'(1);
      fail_q   <= 1'b0;
    end else if (cmd_i.pass_step && rd_valid_q && !fail_q) begin
      if (add_sum > mid_q) begin
        groups_q <= groups_inc;
        sum_q    <= w_ext;
        if (groups_inc > GRP_W'(partition_count_i)) begin
          fail_q <= 1'b1;
        end
      end else begin
        sum_q <= add_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q     <= sat_result(best_q);
      res_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_max_sum_o = res_q;
  assign overflow_o    = res_ovf_q;

  // status to the controller
  assign sts_o.range_ok  = (low_q <= high_q);
  assign sts_o.pass_done = (rd_idx_q == count_q) && !rd_valid_q;
  assign sts_o.fits      = !fail_q;
  assign sts_o.mid_zero  = (mid_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== design/linear_partition_min_max.sv =====
// ----------------------------------------------------------------------------
// linear_partition_min_max: smallest largest group sum of an ordered run
// Items arrive on item_i (weight, last_item), one per cycle while loading;
// each is written to a 1024 entry weight store and folded into the running
// maximum and total. Items beyond the store depth are dropped and flagged.
// After the item marked last_item the block stops taking items and binary
// searches the cap between the maximum and the total. Each candidate picks
// the cap, runs the greedy pass through the single store read port and
// then narrows the bounds. The search takes at most
// floor(log2(total - max + 1)) + 1 candidates, 26 at most. Once the result
// is handed to the output register, loading resumes at one item per cycle.
// The result (min_max_sum, overflow) sits in an output register on
// result_o; while it waits, the next run still loads and searches, but it
// then holds its own result, and the input stays stalled, until the register
// is free. partition_count is written over the APB port at address 0; the
// user writes it only while the block is idle, which the block does not
// enforce; zero acts as one. Reset clears the run, drops any pending result
// and sets partition_count to 1; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_partition_min_max import lpmm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lpmm_item_if.sink                  item_i,
  lpmm_result_if.source              result_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  lpmm_cmd_t        cmd;
  lpmm_sts_t        sts;
  logic [PC_W-1:0]  pc_q;
  logic             reg_sel;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_PARTITION_COUNT);
  assign prdata  = reg_sel ? APB_DATA_W'(pc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pc_q <= pwdata[PC_W-1:0];
    end
  end

  // sequencer
  lpmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_last_i  (item_i.last_item),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  lpmm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .weight_i          (item_i.weight),
    .partition_count_i (pc_q),
    .out_ready_i       (result_o.ready),
    .out_valid_o       (result_o.valid),
    .min_max_sum_o     (result_o.min_max_sum),
    .overflow_o        (result_o.overflow)
  );

endmodule

`default_nettype wire
